FILE: hw/rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // Side-band control that travels with each inverse element.
    typedef struct packed {
        logic valid;   // stage holds a live item
        logic neg;     // result sign (cofactor sign xor det sign)
        logic zero;    // determinant exactly zero
    } t_ctrl;

endpackage

FILE: hw/rtl/mi3_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: 18 element products, then the 9 cofactor differences.
// ----------------------------------------------------------------------------
module mi3_cofactor
    import mi3_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_m   [9],
    output logic                  o_valid,
    output logic signed [2*W:0]   o_cof [9],
    output logic signed [W-1:0]   o_col [3]
);
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [PW-1:0] r_pa [9];
    logic signed [PW-1:0] r_pb [9];
    logic signed [W-1:0]  r_col1 [3];
    logic signed [W-1:0]  r_col2 [3];
    logic [1:0]           r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        localparam int A = (gi + 1) % 3;
        localparam int B = (gi + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_col1[gi] <= i_m[gi*3];
            r_col2[gi] <= r_col1[gi];
        end
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int C = (gj + 1) % 3;
            localparam int D = (gj + 2) % 3;
            always_ff @(posedge i_clk) begin
                r_pa[gi*3+gj]  <= i_m[A*3+C] * i_m[B*3+D];
                r_pb[gi*3+gj]  <= i_m[A*3+D] * i_m[B*3+C];
                o_cof[gi*3+gj] <= CW'(r_pa[gi*3+gj]) - CW'(r_pb[gi*3+gj]);
            end
        end
    end

    assign o_valid = r_vld[1];
    assign o_col   = r_col2;

endmodule

FILE: hw/rtl/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// Four stages: split column-0 partial products, their recombination, the
// determinant sum, then rounding of the determinant and setup of the nine
// dividends and the shared divisor.
// ----------------------------------------------------------------------------
module mi3_det
    import mi3_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int NW = 134,
    parameter int DVW = 101
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [2*W:0]   i_cof [9],
    input  logic signed [W-1:0]   i_col [3],
    output t_ctrl                 o_ctrl [9],
    output logic [NW-1:0]         o_num  [9],
    output logic [DVW-1:0]        o_div,
    output logic signed [W-1:0]   o_det_value
);
    localparam int CW   = 2 * W + 1;
    // cofactor split: low LB bits unsigned, high W bits signed
    localparam int LB   = W + 1;
    localparam int DPW  = 3 * W + 1;
    localparam int DETW = 3 * W + 3;
    localparam int TW   = DETW + 1;
    localparam logic [TW-1:0] HALF = TW'(1) << (2 * F - 1);
    localparam logic [TW-1:0] LIMP = (TW'(1) << (W - 1)) - TW'(1);
    localparam logic [TW-1:0] LIMN = TW'(1) << (W - 1);
    localparam logic [W-1:0]  MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINN = {1'b1, {(W-1){1'b0}}};

    logic signed [2*W-1:0]  r_ph [3];
    logic signed [2*W+1:0]  r_pl [3];
    logic signed [DPW-1:0]  r_dp [3];
    logic signed [CW-1:0]   r_cof3 [9];
    logic signed [CW-1:0]   r_cof4 [9];
    logic signed [CW-1:0]   r_cof5 [9];
    logic signed [DETW-1:0] r_det;
    logic [2:0]             r_vld;

    logic            dneg;
    logic [DETW-1:0] dmag;
    logic [TW-1:0]   drnd;
    logic [W-1:0]    n_detv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ph[k] <= i_col[k] * $signed(i_cof[k*3][CW-1:LB]);
            r_pl[k] <= i_col[k] * $signed({1'b0, i_cof[k*3][LB-1:0]});
            r_dp[k] <= (DPW'(r_ph[k]) <<< LB) + DPW'(r_pl[k]);
        end
        r_cof3 <= i_cof;
        r_cof4 <= r_cof3;
        r_cof5 <= r_cof4;
        r_det  <= DETW'(r_dp[0]) + DETW'(r_dp[1]) + DETW'(r_dp[2]);
    end

    assign dneg = r_det[DETW-1];
    assign dmag = dneg ? DETW'(-r_det) : DETW'(r_det);
    assign drnd = (TW'(dmag) + HALF) >> (2 * F);

    always_comb begin
        if (!dneg) begin
            n_detv = (drnd > LIMP) ? MAXP : W'(drnd);
        end else begin
            n_detv = (drnd > LIMN) ? MINN : W'(-drnd);
        end
    end

    always_ff @(posedge i_clk) begin
        o_div       <= {dmag, 1'b0};
        o_det_value <= n_detv;
    end

    for (genvar gk = 0; gk < 9; gk++) begin : g_num
        logic [CW-1:0] cmag;
        logic          cneg;
        assign cneg = r_cof5[gk][CW-1];
        assign cmag = cneg ? CW'(-r_cof5[gk]) : CW'(r_cof5[gk]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                o_ctrl[gk] <= '0;
            end else begin
                o_ctrl[gk].valid <= r_vld[2];
                o_ctrl[gk].neg   <= cneg ^ dneg;
                o_ctrl[gk].zero  <= (r_det == '0);
            end
            o_num[gk] <= (NW'(cmag) << (2 * F + 1)) + NW'(dmag);
        end
    end

endmodule

FILE: hw/rtl/mi3_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_divider
// Restoring divider, one quotient bit per stage, with overflow detect
// up front and signed saturation at the end.
// ----------------------------------------------------------------------------
module mi3_divider
    import mi3_pkg::*;
#(
    parameter int W   = 32,
    parameter int NW  = 134,
    parameter int DVW = 101
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [NW-1:0]        i_num,
    input  logic [DVW-1:0]       i_div,
    output t_ctrl                o_ctrl,
    output logic signed [W-1:0]  o_res
);
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    t_ctrl          r_ctrl [W+1];
    logic [DVW-1:0] r_rem  [W+1];
    logic [DVW-1:0] r_div  [W+1];
    logic [W-1:0]   r_low  [W+1];
    logic [W-1:0]   r_q    [W+1];
    logic           r_ovf  [W+1];

    logic [NW-W-1:0] hi;
    assign hi = i_num[NW-1:W];

    // entry: high part of the dividend must be below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl[0] <= '0;
        end else begin
            r_ctrl[0] <= i_ctrl;
        end
        r_ovf[0] <= (hi >= i_div);
        r_rem[0] <= DVW'(hi);
        r_div[0] <= i_div;
        r_low[0] <= i_num[W-1:0];
        r_q[0]   <= '0;
    end

    for (genvar gk = 0; gk < W; gk++) begin : g_step
        logic [DVW:0] t;
        logic         ge;
        assign t  = {r_rem[gk], r_low[gk][W-1]};
        assign ge = (t >= {1'b0, r_div[gk]});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[gk+1] <= '0;
            end else begin
                r_ctrl[gk+1] <= r_ctrl[gk];
            end
            r_rem[gk+1] <= ge ? DVW'(t - {1'b0, r_div[gk]}) : DVW'(t);
            r_div[gk+1] <= r_div[gk];
            r_low[gk+1] <= r_low[gk] << 1;
            r_q[gk+1]   <= {r_q[gk][W-2:0], ge};
            r_ovf[gk+1] <= r_ovf[gk];
        end
    end

    logic [W-1:0] q;
    logic         ov;
    logic [W-1:0] n_res;
    assign q  = r_q[W];
    assign ov = r_ovf[W];

    always_comb begin
        if (r_ctrl[W].zero) begin
            n_res = '0;
        end else if (!r_ctrl[W].neg) begin
            n_res = (ov || q[W-1]) ? MAXP : q;
        end else begin
            n_res = (ov || (q[W-1] && (q[W-2:0] != '0))) ? MINN : W'(-q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= r_ctrl[W];
        end
        o_res <= n_res;
    end

endmodule

FILE: hw/rtl/matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// 3x3 signed fixed-point inverse by adjugate over determinant, with exact
// determinant, round-to-nearest (ties away) and saturation.
// ----------------------------------------------------------------------------
// channel   | ports                                   | transfer when
// ----------+-----------------------------------------+------------------
// matrix in | start, busy, i_m00 .. i_m22             | start && !busy
// result    | o_done, o_r00 .. o_r22, o_det_value,    | o_done (1 cycle)
//           | o_singular                              |
//
// The pipeline is 2 cofactor stages, 4 determinant stages, then the divider
// (entry, one stage per quotient bit, saturation). One matrix enters every
// cycle; busy stays low.
// Synchronous active-low reset clears only the valid/neg/zero bits in flight.
// The receiver cannot stall, so nothing inside ever holds.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ELEM_WIDTH-1:0]  i_m00,
    input  logic signed [ELEM_WIDTH-1:0]  i_m01,
    input  logic signed [ELEM_WIDTH-1:0]  i_m02,
    input  logic signed [ELEM_WIDTH-1:0]  i_m10,
    input  logic signed [ELEM_WIDTH-1:0]  i_m11,
    input  logic signed [ELEM_WIDTH-1:0]  i_m12,
    input  logic signed [ELEM_WIDTH-1:0]  i_m20,
    input  logic signed [ELEM_WIDTH-1:0]  i_m21,
    input  logic signed [ELEM_WIDTH-1:0]  i_m22,
    output logic                          o_done,
    output logic signed [ELEM_WIDTH-1:0]  o_r00,
    output logic signed [ELEM_WIDTH-1:0]  o_r01,
    output logic signed [ELEM_WIDTH-1:0]  o_r02,
    output logic signed [ELEM_WIDTH-1:0]  o_r10,
    output logic signed [ELEM_WIDTH-1:0]  o_r11,
    output logic signed [ELEM_WIDTH-1:0]  o_r12,
    output logic signed [ELEM_WIDTH-1:0]  o_r20,
    output logic signed [ELEM_WIDTH-1:0]  o_r21,
    output logic signed [ELEM_WIDTH-1:0]  o_r22,
    output logic signed [ELEM_WIDTH-1:0]  o_det_value,
    output logic                          o_singular
);
    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    // |cofactor| fits 2W+1 bits, |det| fits 3W+3 bits
    localparam int CW   = 2 * W + 1;
    localparam int MAGW = 3 * W + 3;
    localparam int NA   = CW + 2 * F + 1;
    // dividend = |C| * 2^(2F+1) + |det|, divisor = 2*|det|
    localparam int NW   = ((NA > MAGW) ? NA : MAGW) + 1;
    localparam int DVW  = MAGW + 1;
    // determinant waits out the divider: entry + W steps + saturation
    localparam int DLY  = W + 2;

    logic                  in_xfer;
    logic signed [W-1:0]   mat [9];

    logic                  cof_vld;
    logic signed [CW-1:0]  cof [9];
    logic signed [W-1:0]   col [3];

    t_ctrl                 num_ctrl [9];
    logic [NW-1:0]         num [9];
    logic [DVW-1:0]        dvs;
    logic signed [W-1:0]   detv;

    t_ctrl                 div_ctrl [9];
    logic signed [W-1:0]   res [9];

    logic signed [W-1:0]   r_det_dly [DLY];

    // never holds off: the pipeline takes a matrix every cycle
    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    assign mat[0] = i_m00;
    assign mat[1] = i_m01;
    assign mat[2] = i_m02;
    assign mat[3] = i_m10;
    assign mat[4] = i_m11;
    assign mat[5] = i_m12;
    assign mat[6] = i_m20;
    assign mat[7] = i_m21;
    assign mat[8] = i_m22;

    mi3_cofactor #(
        .W (W)
    ) u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_m     (mat),
        .o_valid (cof_vld),
        .o_cof   (cof),
        .o_col   (col)
    );

    mi3_det #(
        .W   (W),
        .F   (F),
        .NW  (NW),
        .DVW (DVW)
    ) u_det (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cof_vld),
        .i_cof       (cof),
        .i_col       (col),
        .o_ctrl      (num_ctrl),
        .o_num       (num),
        .o_div       (dvs),
        .o_det_value (detv)
    );

    // r_ij = C_ji / det: divider k = i*3+j takes cofactor index j*3+i
    for (genvar gi = 0; gi < 3; gi++) begin : g_ri
        for (genvar gj = 0; gj < 3; gj++) begin : g_rj
            mi3_divider #(
                .W   (W),
                .NW  (NW),
                .DVW (DVW)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (num_ctrl[gj*3+gi]),
                .i_num   (num[gj*3+gi]),
                .i_div   (dvs),
                .o_ctrl  (div_ctrl[gi*3+gj]),
                .o_res   (res[gi*3+gj])
            );
        end
    end

    // determinant delay line, aligned with the quotients
    always_ff @(posedge i_clk) begin
        r_det_dly[0] <= detv;
        for (int k = 1; k < DLY; k++) begin
            r_det_dly[k] <= r_det_dly[k-1];
        end
    end

    assign o_done      = div_ctrl[0].valid;
    assign o_singular  = div_ctrl[0].zero;
    assign o_det_value = r_det_dly[DLY-1];
    assign o_r00 = res[0];
    assign o_r01 = res[1];
    assign o_r02 = res[2];
    assign o_r10 = res[3];
    assign o_r11 = res[4];
    assign o_r12 = res[5];
    assign o_r20 = res[6];
    assign o_r21 = res[7];
    assign o_r22 = res[8];

`ifndef ASSERT_OFF
    // divider lanes 0, 4 and 8 must carry the same item
    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_ctrl[4].valid == div_ctrl[0].valid) &&
        (div_ctrl[8].valid == div_ctrl[0].valid) &&
        (div_ctrl[8].zero == div_ctrl[0].zero))
        else $error("divider lanes out of step");

    // singular result: the diagonal, r01 and r20 read zero
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> ((o_r00 == '0) && (o_r11 == '0) && (o_r22 == '0)
                                    && (o_r01 == '0) && (o_r20 == '0)))
        else $error("singular item with nonzero inverse");

    // exact zero determinant must round to zero
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_singular) |-> (o_det_value == '0))
        else $error("determinant delay misaligned with singular flag");
`endif

endmodule

FILE: verif/tb_matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3_unit
// Self-checking bench for the 3x3 fixed-point matrix inverse. A short table of
// directed matrices is followed by random ones with random start gaps. Each
// accepted transfer is predicted with exact wide arithmetic, and every o_done
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3_unit;

    localparam int EW        = 32;
    localparam int FB        = 16;
    localparam int N_RANDOM  = 1530;
    localparam int MAX_GAP   = 16;
    localparam int LATENCY   = EW + 8;
    localparam int CYC_LIMIT = 200000;

    localparam logic signed [EW-1:0] ONE   = 32'sh0001_0000;
    localparam logic signed [EW-1:0] E_MAX = 32'sh7fff_ffff;
    localparam logic signed [EW-1:0] E_MIN = 32'sh8000_0000;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [191:0]  wide_t;   // exact cofactors and determinant

    typedef struct {
        elem_t m[9];                        // row-major
    } matrix_t;

    typedef struct {
        elem_t r[9];                        // inverse, row-major
        elem_t det;
        logic  sing;
    } inverse_t;

    // directed row: matrix plus an optional typed-in answer
    typedef struct {
        matrix_t  mat;
        logic     known;
        inverse_t ans;
    } vec_t;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    elem_t i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22;
    logic  o_done;
    elem_t o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    elem_t o_det_value;
    logic  o_singular;

    matrix_inverse_3x3_unit #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_m00      (i_m00),
        .i_m01      (i_m01),
        .i_m02      (i_m02),
        .i_m10      (i_m10),
        .i_m11      (i_m11),
        .i_m12      (i_m12),
        .i_m20      (i_m20),
        .i_m21      (i_m21),
        .i_m22      (i_m22),
        .o_done     (o_done),
        .o_r00      (o_r00),
        .o_r01      (o_r01),
        .o_r02      (o_r02),
        .o_r10      (o_r10),
        .o_r11      (o_r11),
        .o_r12      (o_r12),
        .o_r20      (o_r20),
        .o_r21      (o_r21),
        .o_r22      (o_r22),
        .o_det_value(o_det_value),
        .o_singular (o_singular)
    );

    inverse_t pending_inv[$];   // predictions waiting for o_done
    int       n_errors;
    int       n_checked;
    int       n_singular;
    int       n_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp a sign/magnitude value to the signed element range.
    function automatic elem_t clamp_elem(wide_t mag, logic neg);
        if (!neg) begin
            if (mag > wide_t'(E_MAX)) return E_MAX;
            return elem_t'(mag);
        end
        if (mag > wide_t'(192'h8000_0000)) return E_MIN;
        return elem_t'(-mag);
    endfunction

    // Adjugate over determinant, exact until the single final rounding.
    function automatic inverse_t invert_matrix(matrix_t a);
        wide_t    e[3][3];
        wide_t    cof[3][3];
        wide_t    det, dmag, cmag, num, quo;
        logic     dneg, rneg;
        int       i1, i2, j1, j2;
        inverse_t res;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = wide_t'(a.m[i*3+j]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                cof[i][j] = e[i1][j1] * e[i2][j2] - e[i1][j2] * e[i2][j1];
            end
        det  = e[0][0] * cof[0][0] + e[1][0] * cof[1][0] + e[2][0] * cof[2][0];
        dneg = det < 0;
        dmag = dneg ? -det : det;
        // determinant carries 3*FB fraction bits; round half away from zero
        res.det  = clamp_elem((dmag + (wide_t'(1) <<< (2*FB - 1))) >>> (2*FB), dneg);
        res.sing = (det == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                if (res.sing) begin
                    res.r[i*3+j] = '0;
                end else begin
                    // transposed cofactor gives the true inverse
                    rneg = (cof[j][i] < 0) != dneg;
                    cmag = (cof[j][i] < 0) ? -cof[j][i] : cof[j][i];
                    num  = (cmag <<< (2*FB + 1)) + dmag;
                    quo  = num / (dmag <<< 1);
                    res.r[i*3+j] = clamp_elem(quo, rneg);
                end
            end
        return res;
    endfunction

    function automatic elem_t rand_elem(int kind);
        case (kind)
            0: return elem_t'($urandom);                                   // any bits
            1: return elem_t'($urandom_range(0, 8 * ONE)) - 4 * ONE;      // +/-4.0
            2: return elem_t'($urandom_range(0, 64)) - 32;                 // tiny raw
            default: begin
                case ($urandom_range(0, 3))
                    0: return E_MAX;
                    1: return E_MIN;
                    2: return '0;
                    default: return ONE;
                endcase
            end
        endcase
    endfunction

    // Mostly well-conditioned matrices, plus rank-deficient and wild ones.
    function automatic matrix_t rand_matrix();
        matrix_t a;
        int      kind, style;
        style = $urandom_range(0, 9);
        kind  = (style < 5) ? 1 : (style < 7) ? 0 : (style < 8) ? 2 : 3;
        for (int k = 0; k < 9; k++) a.m[k] = rand_elem(kind);
        if (style == 9 || $urandom_range(0, 11) == 0) begin
            // force singular: copy a row or a column, or zero a row
            case ($urandom_range(0, 2))
                0: for (int j = 0; j < 3; j++) a.m[6+j] = a.m[j];
                1: for (int i = 0; i < 3; i++) a.m[i*3+2] = a.m[i*3];
                default: for (int j = 0; j < 3; j++) a.m[3+j] = '0;
            endcase
        end
        return a;
    endfunction

    function automatic matrix_t diag(elem_t a, elem_t b, elem_t c);
        matrix_t d;
        foreach (d.m[k]) d.m[k] = '0;
        d.m[0] = a; d.m[4] = b; d.m[8] = c;
        return d;
    endfunction

    function automatic inverse_t diag_ans(elem_t a, elem_t b, elem_t c, elem_t det, logic s);
        inverse_t r;
        matrix_t  d;
        d = diag(a, b, c);
        r.r = d.m; r.det = det; r.sing = s;
        return r;
    endfunction

    // one transfer: idle gap, then hold start until it is taken
    task automatic send_matrix(matrix_t a, inverse_t ans);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_m00 <= a.m[0]; i_m01 <= a.m[1]; i_m02 <= a.m[2];
        i_m10 <= a.m[3]; i_m11 <= a.m[4]; i_m12 <= a.m[5];
        i_m20 <= a.m[6]; i_m21 <= a.m[7]; i_m22 <= a.m[8];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_inv.push_back(ans);
        if (ans.sing) n_singular++;
    endtask

    // compare each o_done transfer with the oldest prediction
    always @(posedge i_clk) begin
        inverse_t want;
        elem_t    got[9];
        if (i_rst_n && o_done) begin
            got = '{o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22};
            if (pending_inv.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: result with nothing outstanding");
            end else begin
                want = pending_inv.pop_front();
                n_checked++;
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.r[k]) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: r%0d%0d exp %h got %h", k / 3, k % 3,
                                     want.r[k], got[k]);
                    end
                if (o_det_value !== want.det) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: det exp %h got %h", want.det, o_det_value);
                end
                if (o_singular !== want.sing) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: singular exp %b got %b", want.sing, o_singular);
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d outstanding", n_cycles,
                     pending_inv.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        vec_t    dir[$];
        vec_t    v;
        matrix_t a;
        int      wait_cyc;

        n_errors = 0; n_checked = 0; n_singular = 0; n_cycles = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} = '0;

        // directed table; answers typed in where they are obvious
        v.known = 1'b1;
        v.mat = diag(ONE, ONE, ONE);   v.ans = diag_ans(ONE, ONE, ONE, ONE, 1'b0);
        dir.push_back(v);
        v.mat = diag(-ONE, -ONE, -ONE); v.ans = diag_ans(-ONE, -ONE, -ONE, -ONE, 1'b0);
        dir.push_back(v);
        v.mat = diag('0, '0, '0);      v.ans = diag_ans('0, '0, '0, '0, 1'b1);
        dir.push_back(v);
        // tiny but nonzero determinant: det rounds to zero, inverse saturates
        v.mat = diag(1, 1, 1);         v.ans = diag_ans(E_MAX, E_MAX, E_MAX, '0, 1'b0);
        dir.push_back(v);
        v.mat = diag(-1, 1, 1);        v.ans = diag_ans(E_MIN, E_MAX, E_MAX, '0, 1'b0);
        dir.push_back(v);
        // all elements equal: rank one, singular
        foreach (v.mat.m[k]) v.mat.m[k] = E_MAX;
        v.ans = diag_ans('0, '0, '0, '0, 1'b1);
        dir.push_back(v);
        foreach (v.mat.m[k]) v.mat.m[k] = E_MIN;
        dir.push_back(v);
        v.known = 1'b0;
        // huge determinant saturates at both ends
        v.mat = diag(E_MAX, E_MAX, E_MAX); dir.push_back(v);
        v.mat = diag(E_MIN, E_MAX, E_MAX); dir.push_back(v);
        v.mat = diag(E_MIN, E_MIN, E_MIN); dir.push_back(v);
        v.mat = diag(2 * ONE, ONE / 2, -4 * ONE); dir.push_back(v);
        v.mat = diag(3 * ONE, 3 * ONE, 3 * ONE); dir.push_back(v);   // rounding of 1/3
        // permutation and general full matrices
        v.mat.m = '{'0, ONE, '0, '0, '0, ONE, ONE, '0, '0}; dir.push_back(v);
        v.mat.m = '{2*ONE, ONE, '0, ONE, 3*ONE, ONE, '0, ONE, 4*ONE}; dir.push_back(v);
        v.mat.m = '{E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, E_MAX, E_MAX, E_MAX, E_MIN};
        dir.push_back(v);
        v.mat.m = '{E_MIN, 1, -1, 1, E_MIN, -1, -1, 1, E_MAX}; dir.push_back(v);
        v.mat.m = '{ONE, 2, '0, 1, ONE, '0, '0, '0, 1}; dir.push_back(v);
        v.mat.m = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 32'shf0f0_f0f0,
                    32'sh3333_3333, 32'shcccc_cccc, 32'sh1234_5678, 32'sh8765_4321,
                    32'sh0000_ffff};
        dir.push_back(v);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[n]) begin
            // typed answers stand in for the predictor where they are known
            send_matrix(dir[n].mat,
                        dir[n].known ? dir[n].ans : invert_matrix(dir[n].mat));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            a = rand_matrix();
            send_matrix(a, invert_matrix(a));
        end
        start <= 1'b0;

        while (pending_inv.size() != 0) @(posedge i_clk);
        wait_cyc = 0;
        while (wait_cyc < 2 * LATENCY) begin
            @(posedge i_clk);
            wait_cyc++;
        end

        $display("covered %0d matrices (%0d singular) incl. saturation and tiny dets",
                 n_checked, n_singular);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
